// File: rtl/tqg_pkg.sv
// ----------------------------------------------------------------------------
// tqg_pkg
// Shared types and constants for the tiled quad generator.
// ----------------------------------------------------------------------------
package tqg_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_TILE_WIDTH   = 3'd0,
    CFG_TILE_HEIGHT  = 3'd1,
    CFG_SPACING_X    = 3'd2,
    CFG_SPACING_Y    = 3'd3,
    CFG_MAX_OFFSET_X = 3'd4,
    CFG_MAX_OFFSET_Y = 3'd5,
    CFG_MODE         = 3'd6,
    CFG_UNUSED       = 3'd7
  } cfg_idx_t;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_PERIOD  = 8'b0000_0010,
    S_MOD_LD  = 8'b0000_0100,
    S_MOD_DIV = 8'b0000_1000,
    S_MOD_FIX = 8'b0001_0000,
    S_COUNT   = 8'b0010_0000,
    S_FRAC    = 8'b0100_0000,
    S_FDIV    = 8'b1000_0000
  } state_t;

  localparam logic [16:0] FRAC_ONE   = 17'd65536;
  localparam int          MIN_PERIOD = 16;
  localparam int          MOD_STEPS  = 20;
  localparam int          FRAC_STEPS = 16;

endpackage

// File: rtl/tqg_if.sv
// ----------------------------------------------------------------------------
// tqg channel interfaces
// Valid/ready channels for scroll input, quad output and register writes.
// ----------------------------------------------------------------------------
interface tqg_in_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] scroll_x;
  logic signed [19:0] scroll_y;
  modport source (output valid, scroll_x, scroll_y, input ready);
  modport sink   (input valid, scroll_x, scroll_y, output ready);
endinterface

interface tqg_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] x_left;
  logic [15:0] x_right;
  logic [15:0] y_bottom;
  logic [15:0] y_top;
  logic [16:0] u_left;
  logic [16:0] u_right;
  logic [16:0] v_bottom;
  logic [16:0] v_top;
  logic        last;
  logic        truncated;
  modport source (output valid, x_left, x_right, y_bottom, y_top, u_left, u_right,
                  v_bottom, v_top, last, truncated, input ready);
  modport sink   (input valid, x_left, x_right, y_bottom, y_top, u_left, u_right,
                  v_bottom, v_top, last, truncated, output ready);
endinterface

interface tqg_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [19:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/tiled_quad_generator.sv
// Sequence: a setup step, then a remainder pass (load, 20 steps, fix) per tiled axis
// or a direct start for an untiled axis, a count walk over the quads (up to
// MAX_QUADS), then per quad four fraction slots, each set directly or by a division,
// plus one output beat that waits for out ready.
// Throughput: one scroll pair at a time; a single shift-subtract divider sets the pace.
// Reset: synchronous active-low; in ready is high only in idle after reset.
// ----------------------------------------------------------------------------
// tiled_quad_generator
// Emits clipped tile quads with texture fractions for one scroll offset pair.
// ----------------------------------------------------------------------------
module tiled_quad_generator #(
  parameter int VIEW_WIDTH  = 1280,
  parameter int VIEW_HEIGHT = 720,
  parameter int MAX_QUADS   = 64
) (
  input  logic clk,
  input  logic rst_n,
  tqg_in_if.sink    in_ch,
  tqg_out_if.source out_ch,
  tqg_cfg_if.sink   cfg_ch
);

  localparam int CW = $clog2(MAX_QUADS + 1);
  localparam logic signed [22:0] VW = 23'(VIEW_WIDTH * 16);
  localparam logic signed [22:0] VH = 23'(VIEW_HEIGHT * 16);

  // configuration
  logic [15:0]        tile_w_r, tile_h_r;
  logic signed [15:0] spc_x_r, spc_y_r;
  logic signed [19:0] moff_x_r, moff_y_r;
  logic [2:0]         mode_r;

  tqg_pkg::state_t state_r, state_nxt;
  logic signed [19:0] scr_x_r, scr_x_nxt, scr_y_r, scr_y_nxt;
  logic [16:0]        px_r, px_nxt, py_r, py_nxt;
  logic signed [20:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [20:0] x_r, x_nxt, y_r, y_nxt;
  logic               axis_r, axis_nxt;
  logic [16:0]        rem_r, rem_nxt, dd_r, dd_nxt;
  logic [19:0]        dv_r, dv_nxt;
  logic [15:0]        q_r, q_nxt;
  logic [4:0]         dcnt_r, dcnt_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt, total_r, total_nxt;
  logic               trunc_r, trunc_nxt;
  logic [1:0]         slot_r, slot_nxt;
  logic [16:0]        ul_r, ul_nxt, ur_r, ur_nxt, vb_r, vb_nxt, vt_r, vt_nxt;
  logic [15:0]        xl_r, xl_nxt, xr_r, xr_nxt, yb_r, yb_nxt, yt_r, yt_nxt;
  logic               ov_r, ov_nxt;

  function automatic logic [15:0] clamp16(input logic signed [22:0] e);
    if (e < 0) return 16'd0;
    else if (e > 23'sd65535) return 16'hFFFF;
    else return e[15:0];
  endfunction

  // config port
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_w_r <= 16'd1024;
      tile_h_r <= 16'd1024;
      spc_x_r  <= '0;
      spc_y_r  <= '0;
      moff_x_r <= 20'sd524287;
      moff_y_r <= 20'sd524287;
      mode_r   <= 3'd3;
    end else if (cfg_ch.valid) begin
      case (tqg_pkg::cfg_idx_t'(cfg_ch.index))
        tqg_pkg::CFG_TILE_WIDTH:   tile_w_r <= cfg_ch.data[15:0];
        tqg_pkg::CFG_TILE_HEIGHT:  tile_h_r <= cfg_ch.data[15:0];
        tqg_pkg::CFG_SPACING_X:    spc_x_r  <= cfg_ch.data[15:0];
        tqg_pkg::CFG_SPACING_Y:    spc_y_r  <= cfg_ch.data[15:0];
        tqg_pkg::CFG_MAX_OFFSET_X: moff_x_r <= cfg_ch.data;
        tqg_pkg::CFG_MAX_OFFSET_Y: moff_y_r <= cfg_ch.data;
        tqg_pkg::CFG_MODE:         mode_r   <= cfg_ch.data[2:0];
        default: ;
      endcase
    end
  end

  // axis sizes
  logic tx, ty, st;
  logic signed [22:0] szx, szy;
  assign tx  = mode_r[0];
  assign ty  = mode_r[1];
  assign st  = mode_r[2];
  assign szx = (!tx && st) ? VW : $signed({7'b0, tile_w_r});
  assign szy = (!ty && st) ? VH : $signed({7'b0, tile_h_r});

  // period of each axis, before the clamp to MIN_PERIOD
  logic signed [22:0] prx, pry;
  assign prx = $signed({7'b0, tile_w_r}) + 23'(spc_x_r);
  assign pry = $signed({7'b0, tile_h_r}) + 23'(spc_y_r);

  // per-axis setup selection
  logic               a_tiled;
  logic signed [22:0] a_off, a_tile, a_spc, a_moff, a_view, a_p, a_start_nt;
  logic signed [22:0] r_s, s_0, s_1;
  always_comb begin
    a_tiled = axis_r ? ty : tx;
    a_off   = axis_r ? 23'(scr_y_r) : 23'(scr_x_r);
    a_tile  = axis_r ? $signed({7'b0, tile_h_r}) : $signed({7'b0, tile_w_r});
    a_spc   = axis_r ? 23'(spc_y_r) : 23'(spc_x_r);
    a_moff  = axis_r ? 23'(moff_y_r) : 23'(moff_x_r);
    a_view  = axis_r ? VH : VW;
    a_p     = axis_r ? $signed({6'b0, py_r}) : $signed({6'b0, px_r});
    if (st || a_tile > a_view) a_start_nt = '0;
    else                       a_start_nt = (a_view - a_tile) >>> 1;
    r_s = (a_off < 0) ? -$signed({6'b0, rem_r}) : $signed({6'b0, rem_r});
    s_0 = (a_off > 0) ? r_s - a_p : r_s;
    if (a_spc < 0 && s_0 > a_spc && (a_moff >= a_p || a_moff - a_off >= a_p))
      s_1 = s_0 - a_p;
    else
      s_1 = s_0;
  end

  // shared shift-subtract step
  logic [17:0] d_t;
  logic        d_ge;
  logic [16:0] d_rem;
  always_comb begin
    d_t   = {rem_r, dv_r[19]};
    d_ge  = d_t >= {1'b0, dd_r};
    d_rem = d_ge ? 17'(d_t - {1'b0, dd_r}) : d_t[16:0];
  end

  // tile walker: row order, left to right
  logic signed [22:0] w_xn, w_yn;
  logic               w_row_end, w_done;
  logic signed [20:0] w_x, w_y;
  always_comb begin
    w_xn      = 23'(x_r) + $signed({6'b0, px_r});
    w_yn      = 23'(y_r) + $signed({6'b0, py_r});
    w_row_end = !tx || w_xn >= VW;
    w_done    = w_row_end && (!ty || w_yn >= VH);
    w_x       = w_row_end ? sx_r : w_xn[20:0];
    w_y       = w_row_end ? w_yn[20:0] : y_r;
  end

  // edges of the current quad
  logic signed [22:0] ex_end, ey_end;
  logic [15:0]        e_xl, e_xr, e_yb, e_yt;
  always_comb begin
    ex_end = 23'(x_r) + szx;
    ey_end = 23'(y_r) + szy;
    if (tx) begin
      e_xl = clamp16((x_r < 0) ? 23'sd0 : 23'(x_r));
      e_xr = clamp16((ex_end < VW) ? ex_end : VW);
    end else begin
      e_xl = clamp16(23'(x_r));
      e_xr = clamp16(ex_end);
    end
    if (ty) begin
      e_yb = clamp16((y_r < 0) ? 23'sd0 : 23'(y_r));
      e_yt = clamp16((ey_end < VH) ? ey_end : VH);
    end else begin
      e_yb = clamp16(23'(y_r));
      e_yt = clamp16(ey_end);
    end
  end

  // fraction slot: 0 u_left, 1 u_right, 2 v_bottom, 3 v_top
  logic               f_tiled, f_need, f_sat;
  logic signed [22:0] f_pos, f_sz, f_view, f_n;
  logic [16:0]        f_dz;
  always_comb begin
    f_tiled = slot_r[1] ? ty : tx;
    f_pos   = slot_r[1] ? 23'(y_r) : 23'(x_r);
    f_sz    = slot_r[1] ? szy : szx;
    f_view  = slot_r[1] ? VH : VW;
    if (!slot_r[0]) begin
      f_need = f_tiled && f_pos < 0;
      f_n    = -f_pos;
    end else begin
      f_need = f_tiled && (f_pos + f_sz) > f_view;
      f_n    = f_view - f_pos;
    end
    f_dz  = (f_sz == 0) ? 17'd1 : f_sz[16:0];
    f_sat = f_n >= $signed({6'b0, f_dz});
  end

  logic        wb;
  logic [16:0] wb_val;
  logic        last_q;
  assign last_q = (cnt_r + CW'(1)) == total_r;

  always_comb begin
    state_nxt = state_r;
    scr_x_nxt = scr_x_r;  scr_y_nxt = scr_y_r;
    px_nxt = px_r;        py_nxt = py_r;
    sx_nxt = sx_r;        sy_nxt = sy_r;
    x_nxt = x_r;          y_nxt = y_r;
    axis_nxt = axis_r;
    rem_nxt = rem_r;      dv_nxt = dv_r;   dd_nxt = dd_r;
    q_nxt = q_r;          dcnt_nxt = dcnt_r;
    cnt_nxt = cnt_r;      total_nxt = total_r;  trunc_nxt = trunc_r;
    slot_nxt = slot_r;
    ul_nxt = ul_r; ur_nxt = ur_r; vb_nxt = vb_r; vt_nxt = vt_r;
    xl_nxt = xl_r; xr_nxt = xr_r; yb_nxt = yb_r; yt_nxt = yt_r;
    ov_nxt = ov_r;
    wb = 1'b0;
    wb_val = '0;

    case (state_r)
      tqg_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          scr_x_nxt = in_ch.scroll_x;
          scr_y_nxt = in_ch.scroll_y;
          state_nxt = tqg_pkg::S_PERIOD;
        end
      end
      tqg_pkg::S_PERIOD: begin
        px_nxt    = (prx < 23'(tqg_pkg::MIN_PERIOD)) ? 17'(tqg_pkg::MIN_PERIOD) : prx[16:0];
        py_nxt    = (pry < 23'(tqg_pkg::MIN_PERIOD)) ? 17'(tqg_pkg::MIN_PERIOD) : pry[16:0];
        axis_nxt  = 1'b0;
        state_nxt = tqg_pkg::S_MOD_LD;
      end
      tqg_pkg::S_MOD_LD: begin
        if (a_tiled) begin
          rem_nxt   = '0;
          dv_nxt    = (a_off < 0) ? 20'(-a_off) : a_off[19:0];
          dd_nxt    = a_p[16:0];
          dcnt_nxt  = 5'(tqg_pkg::MOD_STEPS);
          state_nxt = tqg_pkg::S_MOD_DIV;
        end else if (!axis_r) begin
          sx_nxt   = a_start_nt[20:0];
          axis_nxt = 1'b1;
        end else begin
          sy_nxt    = a_start_nt[20:0];
          x_nxt     = sx_r;
          y_nxt     = a_start_nt[20:0];
          cnt_nxt   = CW'(1);
          state_nxt = tqg_pkg::S_COUNT;
        end
      end
      tqg_pkg::S_MOD_DIV: begin
        rem_nxt  = d_rem;
        dv_nxt   = {dv_r[18:0], 1'b0};
        dcnt_nxt = dcnt_r - 5'd1;
        if (dcnt_r == 5'd1) state_nxt = tqg_pkg::S_MOD_FIX;
      end
      tqg_pkg::S_MOD_FIX: begin
        if (!axis_r) begin
          sx_nxt    = s_1[20:0];
          axis_nxt  = 1'b1;
          state_nxt = tqg_pkg::S_MOD_LD;
        end else begin
          sy_nxt    = s_1[20:0];
          x_nxt     = sx_r;
          y_nxt     = s_1[20:0];
          cnt_nxt   = CW'(1);
          state_nxt = tqg_pkg::S_COUNT;
        end
      end
      tqg_pkg::S_COUNT: begin
        if (w_done || cnt_r == CW'(MAX_QUADS)) begin
          total_nxt = cnt_r;
          trunc_nxt = !w_done;
          x_nxt     = sx_r;
          y_nxt     = sy_r;
          cnt_nxt   = '0;
          slot_nxt  = 2'd0;
          state_nxt = tqg_pkg::S_FRAC;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
          x_nxt   = w_x;
          y_nxt   = w_y;
        end
      end
      tqg_pkg::S_FRAC: begin
        if (ov_r) begin
          // result beat waiting
          if (out_ch.ready) begin
            ov_nxt = 1'b0;
            if (last_q) begin
              state_nxt = tqg_pkg::S_IDLE;
            end else begin
              cnt_nxt  = cnt_r + CW'(1);
              x_nxt    = w_x;
              y_nxt    = w_y;
              slot_nxt = 2'd0;
            end
          end
        end else if (!f_need) begin
          wb     = 1'b1;
          wb_val = slot_r[0] ? tqg_pkg::FRAC_ONE : 17'd0;
        end else if (f_sat) begin
          wb     = 1'b1;
          wb_val = tqg_pkg::FRAC_ONE;
        end else begin
          rem_nxt   = f_n[16:0];
          dv_nxt    = '0;
          dd_nxt    = f_dz;
          dcnt_nxt  = 5'(tqg_pkg::FRAC_STEPS);
          state_nxt = tqg_pkg::S_FDIV;
        end
      end
      tqg_pkg::S_FDIV: begin
        rem_nxt  = d_rem;
        dv_nxt   = {dv_r[18:0], 1'b0};
        q_nxt    = {q_r[14:0], d_ge};
        dcnt_nxt = dcnt_r - 5'd1;
        if (dcnt_r == 5'd1) begin
          wb        = 1'b1;
          wb_val    = {1'b0, q_r[14:0], d_ge};
          state_nxt = tqg_pkg::S_FRAC;
        end
      end
      default: state_nxt = tqg_pkg::S_IDLE;
    endcase

    if (wb) begin
      case (slot_r)
        2'd0:    ul_nxt = wb_val;
        2'd1:    ur_nxt = wb_val;
        2'd2:    vb_nxt = wb_val;
        default: vt_nxt = wb_val;
      endcase
      slot_nxt = slot_r + 2'd1;
      if (slot_r == 2'd3) begin
        xl_nxt = e_xl;  xr_nxt = e_xr;
        yb_nxt = e_yb;  yt_nxt = e_yt;
        ov_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tqg_pkg::S_IDLE;
      ov_r    <= 1'b0;
      cnt_r   <= '0;
      total_r <= '0;
      trunc_r <= 1'b0;
      slot_r  <= '0;
      dcnt_r  <= '0;
      axis_r  <= 1'b0;
      sx_r    <= '0;
      sy_r    <= '0;
      x_r     <= '0;
      y_r     <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      cnt_r   <= cnt_nxt;
      total_r <= total_nxt;
      trunc_r <= trunc_nxt;
      slot_r  <= slot_nxt;
      dcnt_r  <= dcnt_nxt;
      axis_r  <= axis_nxt;
      sx_r    <= sx_nxt;
      sy_r    <= sy_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scr_x_r <= scr_x_nxt;  scr_y_r <= scr_y_nxt;
    px_r <= px_nxt;        py_r <= py_nxt;
    rem_r <= rem_nxt;      dv_r <= dv_nxt;   dd_r <= dd_nxt;  q_r <= q_nxt;
    ul_r <= ul_nxt; ur_r <= ur_nxt; vb_r <= vb_nxt; vt_r <= vt_nxt;
    xl_r <= xl_nxt; xr_r <= xr_nxt; yb_r <= yb_nxt; yt_r <= yt_nxt;
  end

  assign in_ch.ready      = (state_r == tqg_pkg::S_IDLE);
  assign out_ch.valid     = ov_r;
  assign out_ch.x_left    = xl_r;
  assign out_ch.x_right   = xr_r;
  assign out_ch.y_bottom  = yb_r;
  assign out_ch.y_top     = yt_r;
  assign out_ch.u_left    = ul_r;
  assign out_ch.u_right   = ur_r;
  assign out_ch.v_bottom  = vb_r;
  assign out_ch.v_top     = vt_r;
  assign out_ch.last      = last_q;
  assign out_ch.truncated = trunc_r;

`ifndef ASSERT_OFF
  a_no_beat_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("result beat pending while accepting input");

  a_gap_between_quads: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last) |=> !out_ch.valid)
    else $error("next quad shown before its fractions were built");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (cnt_r < total_r && total_r <= CW'(MAX_QUADS)))
    else $error("quad index beyond step count");

  a_div_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tqg_pkg::S_MOD_DIV || state_r == tqg_pkg::S_FDIV) |-> dcnt_r != 5'd0)
    else $error("divider running with zero step count");
`endif

endmodule
